/* hdl/opqt_pkg.sv */
`timescale 1ns / 1ps

package opqt_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int ID_W   = 16;
  localparam int PAY_W  = 32;
  localparam int PRIO_W = 8;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_DEL_POS  = 3'd1,
    CMD_DEL_ID   = 3'd2,
    CMD_READ     = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_DUP_ID    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [PAY_W-1:0] payload;
    logic [PRIO_W-1:0]       prio;
  } entry_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] at;
    entry_t           new_entry;
  } shift_ctrl_t;

endpackage

/* hdl/opqt_cell.sv */
`timescale 1ns / 1ps

module opqt_cell import opqt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] count,
  input  logic             capture,
  input  logic [ID_W-1:0]  probe_id,
  input  shift_ctrl_t      ctrl,
  input  entry_t           left_entry,
  input  entry_t           right_entry,
  output entry_t           entry,
  output logic             hit
);

  entry_t entry_next;

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OP_INS: begin
        if (idx > ctrl.at) begin
          entry_next = left_entry;
        end else if (idx == ctrl.at) begin
          entry_next = ctrl.new_entry;
        end
      end
      OP_DEL: begin
        if (idx >= ctrl.at) begin
          entry_next = right_entry;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // Id compare, qualified by occupancy of this slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (capture) begin
      hit <= (entry.id == probe_id) && (CMP_W'(idx) < CMP_W'(count));
    end
  end

endmodule

/* hdl/ordered_process_queue_table_unit.sv */
`timescale 1ns / 1ps
// Ordered process table held in a shifting row of DEPTH cells.
// Accept captures the request and the id compare; execute shifts the row and registers the
// result once the output register is free. No request is taken while one is executing.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous): length goes to zero, no result pending; cell contents are
// left as they are and are never read above the current length.

module ordered_process_queue_table_unit import opqt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic [POS_W-1:0]         position,
  input  logic [ID_W-1:0]          proc_id,
  input  logic signed [PAY_W-1:0]  payload,
  input  logic [PRIO_W-1:0]        prio,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [LEN_W-1:0]         length,
  output logic                     empty_res,
  output logic [ID_W-1:0]          read_id,
  output logic signed [PAY_W-1:0]  read_payload,
  output logic [PRIO_W-1:0]        read_prio
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // Captured request.
  logic [CMD_W-1:0] cmd_q;
  logic [POS_W-1:0] pos_q;
  entry_t           req_entry;

  logic [CNT_W-1:0] count, count_next;

  logic        accept;
  logic        advance;
  shift_ctrl_t ctrl;

  entry_t     cells [DEPTH];
  logic [DEPTH-1:0] hits;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // Execute only when the output register is free (or being drained now).
  assign advance  = (state == S_EXEC) && (!out_valid || out_ready);

  // ---------------------------------------------------------------------
  // Cell row. Each cell sees both neighbors; the ends are tied off to
  // values that are never selected for an occupied slot.
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = ctrl.new_entry;
    end else begin : g_left
      assign left_in = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = cells[g];
    end else begin : g_right
      assign right_in = cells[g+1];
    end

    opqt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (IDX_W'(g)),
      .count       (count),
      .capture     (accept),
      .probe_id    (proc_id),
      .ctrl        (ctrl),
      .left_entry  (left_in),
      .right_entry (right_in),
      .entry       (cells[g]),
      .hit         (hits[g])
    );
  end

  // ---------------------------------------------------------------------
  // Execute decode
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             pos_ok_ins, pos_ok;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] found_idx;
  logic             found;
  logic             full;
  status_t          stat_next;
  entry_t           rd_next;
  entry_t           rd_sel;

  always_comb begin
    pos_w      = CMP_W'(pos_q);
    cnt_w      = CMP_W'(count);
    pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
    pos_idx    = IDX_W'(pos_w - CMP_W'(1));
    full       = (CMP_W'(count) == CMP_W'(DEPTH));
    found      = |hits;
    // Ids are unique, so at most one hit: OR of the hit indexes.
    found_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hits[i]) begin
        found_idx = found_idx | IDX_W'(i);
      end
    end
  end

  assign rd_sel = cells[pos_idx];

  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.at        = pos_idx;
    ctrl.new_entry = req_entry;
    count_next     = count;
    stat_next      = ST_OK;
    rd_next        = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (!pos_ok_ins) begin
          stat_next = ST_BAD_POS;
        end else if (found) begin
          stat_next = ST_DUP_ID;
        end else if (full) begin
          stat_next = ST_FULL;
        end else begin
          ctrl.op    = OP_INS;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DEL_POS: begin
        if (!pos_ok) begin
          stat_next = ST_BAD_POS;
        end else begin
          ctrl.op    = OP_DEL;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_DEL_ID: begin
        ctrl.at = found_idx;
        if (!found) begin
          stat_next = ST_NOT_FOUND;
        end else begin
          ctrl.op    = OP_DEL;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          stat_next = ST_BAD_POS;
        end else begin
          rd_next = rd_sel;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unknown commands leave the table alone
      end
    endcase
    if (!advance) begin
      ctrl.op    = OP_HOLD;
      count_next = count;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (advance) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture (payload, no reset).
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q             <= command;
      pos_q             <= position;
      req_entry.id      <= proc_id;
      req_entry.payload <= payload;
      req_entry.prio    <= prio;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= stat_next;
      length       <= LEN_W'(count_next);
      empty_res    <= (count_next == '0);
      read_id      <= rd_next.id;
      read_payload <= rd_next.payload;
      read_prio    <= rd_next.prio;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("entry count above DEPTH");

  a_hits_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(hits))
    else $error("more than one cell matched the id");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    advance |=> (state == S_IDLE) && out_valid)
    else $error("execute did not produce a result");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_INS) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count))
    else $error("table length changed without a request");
`endif

endmodule

/* bench/ordered_process_queue_table_unit_tb.sv */
`timescale 1ns / 1ps

module ordered_process_queue_table_unit_tb;
  import opqt_pkg::*;

  // Highest code the command field can carry; codes above CMD_CLEAR are no-ops.
  localparam logic [CMD_W-1:0] CMD_CODE_MAX = '1;
  // Cycles with no request or result accepted before the run is called hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Settle time after the last result, so a late stray result is still seen.
  localparam int unsigned TAIL_CYCLES = 10;

  // Expected content of one result.
  typedef struct {
    status_t                 status;
    logic [LEN_W-1:0]        length;
    logic                    empty_res;
    logic [ID_W-1:0]         read_id;
    logic signed [PAY_W-1:0] read_payload;
    logic [PRIO_W-1:0]       read_prio;
  } table_result_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic [ID_W-1:0]         proc_id;
  logic signed [PAY_W-1:0] payload;
  logic [PRIO_W-1:0]       prio;
  logic                    out_valid;
  logic                    out_ready;
  logic [STAT_W-1:0]       status;
  logic [LEN_W-1:0]        length;
  logic                    empty_res;
  logic [ID_W-1:0]         read_id;
  logic signed [PAY_W-1:0] read_payload;
  logic [PRIO_W-1:0]       read_prio;

  // Shadow copy of the table, head at index 0.
  entry_t        shadow_table[$];
  // Results predicted at request accept, oldest first.
  table_result_t pending_results[$];

  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  ordered_process_queue_table_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .position     (position),
    .proc_id      (proc_id),
    .payload      (payload),
    .prio         (prio),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .length       (length),
    .empty_res    (empty_res),
    .read_id      (read_id),
    .read_payload (read_payload),
    .read_prio    (read_prio)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Index of the entry holding this id, or -1 when absent.
  function automatic int find_entry(input logic [ID_W-1:0] id);
    foreach (shadow_table[i]) begin
      if (shadow_table[i].id == id) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the result it must produce.
  function automatic table_result_t apply_table_command(
    input logic [CMD_W-1:0]        cmd,
    input logic [POS_W-1:0]        pos,
    input logic [ID_W-1:0]         id,
    input logic signed [PAY_W-1:0] pay,
    input logic [PRIO_W-1:0]       pr
  );
    table_result_t res;
    entry_t        ent;
    int            n;
    int            hit;
    n   = shadow_table.size();
    res = '{status: ST_OK, length: '0, empty_res: 1'b0,
            read_id: '0, read_payload: '0, read_prio: '0};
    case (cmd)
      CMD_INSERT: begin
        // Checks in priority order: position, duplicate id, capacity.
        if (pos < 1 || pos > n + 1) begin
          res.status = ST_BAD_POS;
        end else if (find_entry(id) >= 0) begin
          res.status = ST_DUP_ID;
        end else if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ent.id      = id;
          ent.payload = pay;
          ent.prio    = pr;
          shadow_table.insert(pos - 1, ent);
        end
      end
      CMD_DEL_POS: begin
        if (pos < 1 || pos > n) res.status = ST_BAD_POS;
        else shadow_table.delete(pos - 1);
      end
      CMD_DEL_ID: begin
        hit = find_entry(id);
        if (hit < 0) res.status = ST_NOT_FOUND;
        else shadow_table.delete(hit);
      end
      CMD_READ: begin
        if (pos < 1 || pos > n) begin
          res.status = ST_BAD_POS;
        end else begin
          res.read_id      = shadow_table[pos - 1].id;
          res.read_payload = shadow_table[pos - 1].payload;
          res.read_prio    = shadow_table[pos - 1].prio;
        end
      end
      CMD_CLEAR: shadow_table.delete();
      default: ;  // undefined codes leave the table alone
    endcase
    res.length    = LEN_W'(shadow_table.size());
    res.empty_res = (shadow_table.size() == 0);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept,
  // with in_valid still high so a following request can reuse the cycle.
  task automatic send_request(
    input logic [CMD_W-1:0]        cmd,
    input logic [POS_W-1:0]        pos,
    input logic [ID_W-1:0]         id,
    input logic signed [PAY_W-1:0] pay,
    input logic [PRIO_W-1:0]       pr
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    position = pos;
    proc_id  = id;
    payload  = pay;
    prio     = pr;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(),
                           apply_table_command(cmd, pos, id, pay, pr));
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] unused_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom); while (find_entry(id) >= 0);
    return id;
  endfunction

  // Walk through the corner cases one by one: empty table, field extremes,
  // head/tail/middle edits, duplicate ids, id zero, undefined codes.
  task automatic test_directed_corners();
    logic [CMD_W-1:0] code;
    send_request(CMD_READ,    8'd1,   16'h0000, 32'sd0, 8'd0);   // read on empty
    send_request(CMD_DEL_POS, 8'd1,   16'h0000, 32'sd0, 8'd0);   // delete on empty
    send_request(CMD_DEL_ID,  8'd0,   16'h0000, 32'sd0, 8'd0);   // id delete on empty
    send_request(CMD_INSERT,  8'd0,   16'h1234, 32'sd5, 8'd1);   // position zero
    send_request(CMD_INSERT,  8'd2,   16'h1234, 32'sd5, 8'd1);   // past the tail
    send_request(CMD_INSERT,  8'd1,   16'h0000, 32'h8000_0000, 8'h00);  // id zero
    send_request(CMD_INSERT,  8'd2,   16'hFFFF, 32'h7FFF_FFFF, 8'hFF);  // append
    send_request(CMD_INSERT,  8'd1,   16'hA5A5, 32'h5A5A_A5A5, 8'h5A);  // new head
    send_request(CMD_INSERT,  8'd2,   16'hFFFF, 32'sd1, 8'd1);   // duplicate id
    send_request(CMD_INSERT,  8'd2,   16'h0000, 32'sd1, 8'd1);   // duplicate id zero
    send_request(CMD_READ,    8'd1,   16'h0000, 32'sd0, 8'd0);
    send_request(CMD_READ,    8'd3,   16'h0000, 32'sd0, 8'd0);
    send_request(CMD_READ,    8'd4,   16'h0000, 32'sd0, 8'd0);   // one past the tail
    send_request(CMD_READ,    8'hFF,  16'hFFFF, 32'sd0, 8'hFF);  // position max
    for (code = CMD_W'(CMD_CLEAR + 1); code != '0; code = code + 1'b1) begin
      send_request(code, 8'd1, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    end
    send_request(CMD_DEL_ID,  8'd0,   16'h0000, 32'sd0, 8'd0);   // middle entry by id
    send_request(CMD_DEL_ID,  8'd0,   16'h0000, 32'sd0, 8'd0);   // now missing
    send_request(CMD_DEL_POS, 8'd2,   16'h0000, 32'sd0, 8'd0);   // tail
    send_request(CMD_DEL_POS, 8'd0,   16'h0000, 32'sd0, 8'd0);
    send_request(CMD_CLEAR,   8'hFF,  16'hFFFF, 32'sd0, 8'd0);
    send_request(CMD_CLEAR,   8'd0,   16'h0000, 32'sd0, 8'd0);   // clear when empty
    drain_results();
  endtask

  // Fill to capacity, probe the full-table checks, read back, empty by id.
  task automatic test_fill_to_capacity();
    int n;
    send_request(CMD_CLEAR, 8'd0, 16'h0000, 32'sd0, 8'd0);
    repeat (DEPTH) begin
      n = shadow_table.size();
      send_request(CMD_INSERT, POS_W'($urandom_range(1, n + 1)), unused_id(), $urandom,
                   PRIO_W'($urandom_range(255)));
    end
    send_request(CMD_INSERT, POS_W'($urandom_range(1, DEPTH + 1)), unused_id(), $urandom,
                 8'd7);
    send_request(CMD_INSERT, 8'd1, shadow_table[DEPTH - 1].id, $urandom, 8'd7);
    send_request(CMD_INSERT, POS_W'(DEPTH + 2), unused_id(), $urandom, 8'd7);
    for (int p = 1; p <= DEPTH; p++) begin
      send_request(CMD_READ, POS_W'(p), ID_W'($urandom), $urandom,
                   PRIO_W'($urandom_range(255)));
    end
    drain_results();
    while (shadow_table.size() != 0) begin
      n = shadow_table.size();
      send_request(CMD_DEL_ID, POS_W'($urandom), shadow_table[$urandom_range(n - 1)].id,
                   $urandom, PRIO_W'($urandom_range(255)));
    end
    drain_results();
  endtask

  // Mostly well-formed commands against the live table, with some noise.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned      roll;
    int               n;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  id;
    repeat (count) begin
      n    = shadow_table.size();
      roll = $urandom_range(99);
      if (roll < 40)      cmd = CMD_INSERT;
      else if (roll < 55) cmd = CMD_DEL_POS;
      else if (roll < 70) cmd = CMD_DEL_ID;
      else if (roll < 92) cmd = CMD_READ;
      else if (roll < 96) cmd = CMD_CLEAR;
      else                cmd = CMD_W'($urandom_range(CMD_CLEAR + 1, CMD_CODE_MAX));

      if ($urandom_range(9) < 2)  pos = POS_W'($urandom);
      else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(1, n + 1));
      else if (n == 0)            pos = POS_W'($urandom_range(1, 2));
      else                        pos = POS_W'($urandom_range(1, n));

      id = ID_W'($urandom);
      if (n > 0 && ((cmd == CMD_DEL_ID && $urandom_range(3) != 0) ||
                    (cmd == CMD_INSERT && $urandom_range(6) == 0))) begin
        id = shadow_table[$urandom_range(n - 1)].id;
      end
      send_request(cmd, pos, id, $urandom, PRIO_W'($urandom_range(255)));
    end
    drain_results();
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Result side: random back-pressure, driven on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    table_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, status 0x%0h length %0d",
                 $time, status, length);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("status",       exp_res.status,       status);
        compare_field("length",       exp_res.length,       length);
        compare_field("empty_res",    exp_res.empty_res,    empty_res);
        compare_field("read_id",      exp_res.read_id,      read_id);
        compare_field("read_payload", exp_res.read_payload, read_payload);
        compare_field("read_prio",    exp_res.read_prio,    read_prio);
      end
    end
  end

  // Hang detector: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    command       = '0;
    position      = '0;
    proc_id       = '0;
    payload       = '0;
    prio          = '0;
    error_count   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 20;
    recv_idle_pct = 65;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_corners();
    test_fill_to_capacity();
    test_random_traffic(165);
    // Swap the pressure: slow sender, mostly-ready receiver.
    send_idle_pct = 65;
    recv_idle_pct = 20;
    test_random_traffic(165);
    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(170);

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Any stray result in this window is flagged by the checker.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/opqt_pkg.sv
hdl/opqt_cell.sv
hdl/ordered_process_queue_table_unit.sv
bench/ordered_process_queue_table_unit_tb.sv
